### sv/deps_pkg.sv
// ----------------------------------------------------------------------------
// Elastic pair score package
// Shared constants, the envelope ROM and the queue word layout.
// ----------------------------------------------------------------------------
package deps_pkg;

  localparam int MAX_ALIGNED     = 1024;
  localparam int TABLE_SIZE      = 100;
  localparam int ENVELOPE_RADIUS = 20;

  localparam int DIST_W   = 16;
  localparam int SUM_W    = 48;
  localparam int CFG_W    = 16;
  localparam int LEN_W    = 11;
  localparam int IDX_W    = $clog2(TABLE_SIZE);
  localparam int W_W      = 17;          // envelope weight, Q1.16
  localparam int Q_W      = 18;          // ratio of twice the difference to the sum, Q.16
  localparam int NUM_W    = SUM_W + 1;

  // Pairs whose mean distance is above 100 angstroms carry no weight.
  localparam logic [DIST_W:0] S_LIMIT = 17'd51200;

  // The score is divided by 100 one 16-bit digit at a time; each digit
  // quotient comes from a reciprocal multiplication that is exact for
  // dividends below 100 * 2^16.
  localparam int SCORE_DIV  = 100;
  localparam int DIG_W      = 16;
  localparam int DIG_V_W    = 7 + DIG_W;
  localparam int RECIP_W    = 24;
  localparam int RECIP_SH   = 30;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((64'd1 << RECIP_SH) / SCORE_DIV + 1);

  localparam int DIV_STEPS  = Q_W;
  localparam int SDIV_STEPS = SUM_W / DIG_W;

  localparam int CFG_IDX_W      = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ELASTIC_OFFSET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAG_BONUS     = 8'd1;
  localparam logic [CFG_W-1:0]     CFG_RESET_VALUE    = 16'd13107;

  // One classified pair, as handed from the front to the back.
  typedef struct packed {
    logic [DIST_W:0]   s;
    logic [DIST_W-1:0] diff;
    logic [IDX_W-1:0]  idx;
    logic              in_rng;
    logic              last;
    logic [LEN_W-1:0]  len;
  } deps_item_t;

  typedef logic [W_W-1:0] env_rom_t [TABLE_SIZE];

  // Unsigned quotient by shift and subtract, used only while building the ROM.
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = 64'd0;
    r = 64'd0;
    for (int bi = 63; bi >= 0; bi--) begin
      r = {r[62:0], n[bi]};
      if (r >= d) begin
        r     = r - d;
        q[bi] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f) for f in [0,1] in Q2.30, series with truncated terms.
  function automatic longint unsigned exp_frac(longint unsigned f);
    longint          acc;
    longint unsigned term;
    acc  = longint'(64'd1 << 30);
    term = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      term = udiv((term * f) >> 30, 64'(k));
      if (k[0]) acc = acc - longint'(term);
      else      acc = acc + longint'(term);
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  // Gaussian envelope exp(-i*i/R^2) rounded to Q1.16.
  function automatic env_rom_t build_env();
    env_rom_t        rom;
    longint unsigned rr, e1, sq, n, f, v;
    rr = longint'(ENVELOPE_RADIUS) * longint'(ENVELOPE_RADIUS);
    e1 = exp_frac(64'd1 << 30);
    for (int i = 0; i < TABLE_SIZE; i++) begin
      sq = longint'(i) * longint'(i);
      n  = udiv(sq, rr);
      f  = udiv((sq - n * rr) << 30, rr);
      v  = exp_frac(f);
      while (n > 0 && v != 0) begin
        v = (v * e1) >> 30;
        n = n - 1;
      end
      rom[i] = W_W'((v + (64'd1 << 13)) >> 14);
    end
    return rom;
  endfunction

  localparam env_rom_t ENV_ROM = build_env();

endpackage

### sv/deps_if.sv
// ----------------------------------------------------------------------------
// Elastic pair score channels
// Valid/ready channels for pairs, results and register writes.
// ----------------------------------------------------------------------------
interface deps_in_if;
  import deps_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] dist_query;
  logic [DIST_W-1:0] dist_target;
  logic              last;
  logic [LEN_W-1:0]  aligned_len;
  modport source (output valid, dist_query, dist_target, last, aligned_len, input ready);
  modport sink   (input valid, dist_query, dist_target, last, aligned_len, output ready);
endinterface

interface deps_out_if;
  import deps_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] off_diag_sum;
  logic signed [SUM_W-1:0] final_score;
  modport source (output valid, off_diag_sum, final_score, input ready);
  modport sink   (input valid, off_diag_sum, final_score, output ready);
endinterface

interface deps_cfg_if;
  import deps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

### sv/deps_front.sv
// ----------------------------------------------------------------------------
// Elastic pair score front end
// Takes a pair word, forms sum, difference and envelope index.
// ----------------------------------------------------------------------------
module deps_front
  import deps_pkg::*;
(
  deps_in_if.sink   in_ch,
  output logic       push,
  output deps_item_t push_item,
  input  logic       full
);

  logic [DIST_W:0] s;
  logic [DIST_W:0] idx_raw;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  always_comb begin
    s       = {1'b0, in_ch.dist_query} + {1'b0, in_ch.dist_target};
    idx_raw = (s + 17'd256) >> 9;
    push_item.s      = s;
    push_item.diff   = (in_ch.dist_query > in_ch.dist_target) ?
                       in_ch.dist_query - in_ch.dist_target :
                       in_ch.dist_target - in_ch.dist_query;
    push_item.idx    = (idx_raw > 17'(TABLE_SIZE - 1)) ? IDX_W'(TABLE_SIZE - 1)
                                                        : idx_raw[IDX_W-1:0];
    push_item.in_rng = (s <= S_LIMIT);
    push_item.last   = in_ch.last;
    push_item.len    = in_ch.aligned_len;
  end

endmodule

### sv/deps_queue.sv
// ----------------------------------------------------------------------------
// Elastic pair score queue
// Two-entry queue between the front end and the scoring engine.
// ----------------------------------------------------------------------------
module deps_queue
  import deps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  deps_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output deps_item_t head
);

  deps_item_t  mem_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### sv/deps_back.sv
// ----------------------------------------------------------------------------
// Elastic pair score engine
// Divides, weights and accumulates each pair; forms the score at the end.
// ----------------------------------------------------------------------------
module deps_back
  import deps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              not_empty,
  input  deps_item_t        head,
  output logic              pop,
  input  logic [CFG_W-1:0]  elastic_offset,
  input  logic [CFG_W-1:0]  diag_bonus,
  deps_out_if.source        out_ch
);

  localparam logic [2:0] ST_POP = 3'd0;
  localparam logic [2:0] ST_DIV = 3'd1;
  localparam logic [2:0] ST_MUL = 3'd2;
  localparam logic [2:0] ST_ACC = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;
  localparam logic [2:0] ST_SDV = 3'd5;
  localparam logic [2:0] ST_OUT = 3'd6;

  logic [2:0]              state_r;
  deps_item_t              ent_r;
  logic [Q_W-1:0]          rem_r, quo_r;
  logic [5:0]              cnt_r;
  logic signed [W_W+Q_W+1:0] prod_r;
  logic signed [SUM_W-1:0] sum_r, tot_r;
  logic                    neg_r;
  logic [SUM_W-1:0]        dv_r;
  logic [6:0]              srem_r;
  logic                    out_valid_r;
  logic signed [SUM_W-1:0] out_sum_r, out_score_r;

  logic                    trial;
  logic [Q_W-1:0]          rem_sub;
  logic signed [Q_W:0]     dterm;
  logic signed [W_W+Q_W+1:0] prod_rnd;
  logic signed [SUM_W:0]   acc_wide;
  logic signed [SUM_W-1:0] acc_sat;
  logic [LEN_W-1:0]        len_c;
  logic [LEN_W+CFG_W-1:0]  bonus;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        mag;
  logic [DIG_V_W-1:0]      dig_v;
  logic [DIG_V_W+RECIP_W-1:0] dig_prod;
  logic [DIG_W-1:0]        dig_q;
  logic [DIG_V_W-1:0]      dig_rem;
  logic                    load_out;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.off_diag_sum = out_sum_r;
  assign out_ch.final_score  = out_score_r;
  assign pop      = (state_r == ST_POP) && not_empty;
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    trial    = rem_r >= {1'b0, ent_r.s};
    rem_sub  = trial ? rem_r - {1'b0, ent_r.s} : rem_r;
    dterm    = $signed({3'b0, elastic_offset}) - $signed({1'b0, quo_r});
    prod_rnd = (prod_r + 37'sd32768) >>> 16;
    acc_wide = {sum_r[SUM_W-1], sum_r}
             + (ent_r.in_rng ? (SUM_W+1)'(prod_rnd) : '0);
    if (acc_wide[SUM_W] != acc_wide[SUM_W-1])
      acc_sat = acc_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      acc_sat = acc_wide[SUM_W-1:0];
    len_c = (ent_r.len > LEN_W'(MAX_ALIGNED)) ? LEN_W'(MAX_ALIGNED) : ent_r.len;
    bonus = len_c * diag_bonus;
    num   = {tot_r[SUM_W-1], tot_r} + $signed(NUM_W'(bonus));
    mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    // One digit of the score division: the remainder so far in front of the
    // next 16 bits of the dividend.
    dig_v    = {srem_r, dv_r[SUM_W-1 -: DIG_W]};
    dig_prod = dig_v * RECIP_100;
    dig_q    = dig_prod[RECIP_SH +: DIG_W];
    dig_rem  = dig_v - DIG_V_W'(dig_q) * DIG_V_W'(SCORE_DIV);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_POP: begin
        ent_r <= head;
        rem_r <= {2'b0, head.diff};
        quo_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        quo_r <= {quo_r[Q_W-2:0], trial};
        rem_r <= {rem_sub[Q_W-2:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
      end
      ST_MUL: prod_r <= $signed({1'b0, ENV_ROM[ent_r.idx]}) * dterm;
      ST_ACC: tot_r <= acc_sat;
      ST_FIN: begin
        neg_r  <= num[NUM_W-1];
        dv_r   <= SUM_W'(mag + NUM_W'(50));
        srem_r <= '0;
        cnt_r  <= '0;
      end
      ST_SDV: begin
        srem_r <= dig_rem[6:0];
        dv_r   <= {dv_r[SUM_W-DIG_W-1:0], dig_q};
        cnt_r  <= cnt_r + 6'd1;
      end
      default: ;
    endcase
    if (load_out) begin
      out_sum_r   <= tot_r;
      out_score_r <= neg_r ? SUM_W'(-dv_r) : SUM_W'(dv_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_POP;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out)                         out_valid_r <= 1'b1;
      else if (out_ch.ready)                out_valid_r <= 1'b0;
      case (state_r)
        ST_POP: if (not_empty) begin
          // A zero sum or an out-of-range pair needs no division.
          state_r <= (head.in_rng && head.s != '0) ? ST_DIV : ST_MUL;
        end
        ST_DIV: if (cnt_r == 6'(DIV_STEPS - 1)) state_r <= ST_MUL;
        ST_MUL: state_r <= ST_ACC;
        ST_ACC: begin
          if (ent_r.last) begin
            sum_r   <= '0;
            state_r <= ST_FIN;
          end else begin
            sum_r   <= acc_sat;
            state_r <= ST_POP;
          end
        end
        ST_FIN: state_r <= ST_SDV;
        ST_SDV: if (cnt_r == 6'(SDIV_STEPS - 1)) state_r <= ST_OUT;
        ST_OUT: if (load_out) state_r <= ST_POP;
        default: state_r <= ST_POP;
      endcase
    end
  end

endmodule

### sv/dali_elastic_pair_score.sv
// ----------------------------------------------------------------------------
// Elastic pair score
// Top level: register file, front end, queue and scoring engine.
// ----------------------------------------------------------------------------
// Each pair word goes through the scoring engine in order: queue pop, the
// bit-serial ratio divider, the weight multiply and the accumulate; a pair
// with a zero or out-of-range distance sum skips the divider. A word marked
// last then forms the score numerator, divides it by 100 in 16-bit digits
// by reciprocal multiplication and loads the result register once that
// register is free or its word is taken. A two-word queue lets the front
// take pairs while the engine works, and the result register lets the
// engine go on while a result word waits to be taken.
module dali_elastic_pair_score
  import deps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  deps_in_if.sink     in_ch,
  deps_out_if.source  out_ch,
  deps_cfg_if.sink    cfg_ch
);

  logic [CFG_W-1:0] elastic_offset_r, diag_bonus_r;
  logic             push, full, pop, not_empty;
  deps_item_t       push_item, head;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elastic_offset_r <= CFG_RESET_VALUE;
      diag_bonus_r     <= CFG_RESET_VALUE;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_ELASTIC_OFFSET: elastic_offset_r <= cfg_ch.wr_data;
        CFG_DIAG_BONUS:     diag_bonus_r     <= cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  deps_front u_front (
    .in_ch     (in_ch),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  deps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  deps_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .not_empty      (not_empty),
    .head           (head),
    .pop            (pop),
    .elastic_offset (elastic_offset_r),
    .diag_bonus     (diag_bonus_r),
    .out_ch         (out_ch)
  );

endmodule
